// ===== src/msm_pkg.sv =====
// ----------------------------------------------------------------------------
// msm_pkg
// Shared types and constants of the microcoded stack machine datapath:
// control word layout, bus codes, memory geometry and stream packing.
// ----------------------------------------------------------------------------
package msm_pkg;

    localparam int WORD_W      = 32;
    localparam int BYTE_W      = 8;
    localparam int LANES       = WORD_W / BYTE_W;

    // Main memory, byte addressed, held as words with byte lanes
    localparam int MEMORY_BYTES = 65536;
    localparam int MEM_AW       = $clog2(MEMORY_BYTES);
    localparam int MEM_WORDS    = MEMORY_BYTES / LANES;
    localparam int MEM_WAW      = MEM_AW - 2;

    // Control store
    localparam int CS_DEPTH = 512;
    localparam int CS_AW    = $clog2(CS_DEPTH);
    localparam int CW_W     = 36;

    // Register file, ordered as the C-bus enable bits
    localparam int NUM_REGS  = 9;
    localparam int REG_IDX_W = 4;
    localparam logic [REG_IDX_W-1:0] REG_MAR = 4'd0;
    localparam logic [REG_IDX_W-1:0] REG_MDR = 4'd1;
    localparam logic [REG_IDX_W-1:0] REG_PC  = 4'd2;
    localparam logic [REG_IDX_W-1:0] REG_SP  = 4'd3;
    localparam logic [REG_IDX_W-1:0] REG_LV  = 4'd4;
    localparam logic [REG_IDX_W-1:0] REG_CPP = 4'd5;
    localparam logic [REG_IDX_W-1:0] REG_TOS = 4'd6;
    localparam logic [REG_IDX_W-1:0] REG_OPC = 4'd7;
    localparam logic [REG_IDX_W-1:0] REG_H   = 4'd8;

    // B bus sources
    localparam logic [3:0] BSEL_MDR  = 4'd0;
    localparam logic [3:0] BSEL_PC   = 4'd1;
    localparam logic [3:0] BSEL_MBRU = 4'd2;
    localparam logic [3:0] BSEL_MBR  = 4'd3;
    localparam logic [3:0] BSEL_SP   = 4'd4;
    localparam logic [3:0] BSEL_LV   = 4'd5;
    localparam logic [3:0] BSEL_CPP  = 4'd6;
    localparam logic [3:0] BSEL_TOS  = 4'd7;
    localparam logic [3:0] BSEL_OPC  = 4'd8;

    // ALU functions
    localparam logic [5:0] ALU_AND       = 6'd12;
    localparam logic [5:0] ALU_ONE       = 6'd17;
    localparam logic [5:0] ALU_MINUS_ONE = 6'd18;
    localparam logic [5:0] ALU_PASS_B    = 6'd20;
    localparam logic [5:0] ALU_PASS_H    = 6'd24;
    localparam logic [5:0] ALU_NOT_H     = 6'd26;
    localparam logic [5:0] ALU_OR        = 6'd28;
    localparam logic [5:0] ALU_NOT_B     = 6'd44;
    localparam logic [5:0] ALU_INC_B     = 6'd53;
    localparam logic [5:0] ALU_DEC_B     = 6'd54;
    localparam logic [5:0] ALU_INC_H     = 6'd57;
    localparam logic [5:0] ALU_NEG_H     = 6'd59;
    localparam logic [5:0] ALU_ADD       = 6'd60;
    localparam logic [5:0] ALU_ADD_INC   = 6'd61;
    localparam logic [5:0] ALU_B_MINUS_H = 6'd63;

    // Shifter
    localparam logic [1:0] SH_SRL1 = 2'd1;
    localparam logic [1:0] SH_SLL8 = 2'd2;

    // Memory and jump control bits
    localparam int MEM_FETCH_BIT = 0;
    localparam int MEM_READ_BIT  = 1;
    localparam int MEM_WRITE_BIT = 2;
    localparam int JAM_Z_BIT     = 0;
    localparam int JAM_NZ_BIT    = 1;
    localparam int JAM_MPC_BIT   = 2;

    // Item kinds
    localparam logic [1:0] MODE_EXEC = 2'd0;
    localparam logic [1:0] MODE_CS   = 2'd1;
    localparam logic [1:0] MODE_MEM  = 2'd2;

    localparam int S_TDATA_W = 56;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 312;

    typedef struct packed {
        logic [CS_AW-1:0] next_addr;
        logic [2:0]       jam;
        logic [1:0]       shift;
        logic [5:0]       alu_op;
        logic [8:0]       c_en;
        logic [2:0]       mem_op;
        logic [3:0]       b_sel;
    } cw_t;

    typedef struct packed {
        logic [LANES-1:0]  be;
        logic [MEM_WAW-1:0] addr;
        logic [WORD_W-1:0] data;
    } mem_wr_t;

    // Result packing, last field (next_mpc) in the lowest bits
    typedef struct packed {
        logic [5:0]        pad;
        logic [WORD_W-1:0] h;
        logic [WORD_W-1:0] opc;
        logic [WORD_W-1:0] tos;
        logic [WORD_W-1:0] cpp;
        logic [WORD_W-1:0] lv;
        logic [WORD_W-1:0] sp;
        logic [BYTE_W-1:0] mbr;
        logic [WORD_W-1:0] pc;
        logic [WORD_W-1:0] mdr;
        logic [WORD_W-1:0] mar;
        logic              zero;
        logic [CS_AW-1:0]  next_mpc;
    } res_t;

endpackage

// ===== src/microcoded_stack_machine_datapath_unit.sv =====
// ----------------------------------------------------------------------------
// microcoded_stack_machine_datapath_unit
// Steps: control-store read, then decode/ALU/register write with the main
//   memory read issued, then memory data, next address and result register;
//   the last step waits while the output register is still held.
// Issue: the control-store read feeds the main-memory read whose fetched
//   byte forms the next address, so a new item is accepted only in the last
//   step of a microstep. Load items also wait for the output register.
// Reset: registers and flags clear at once; then a clearing pass zeroes every
//   word of main memory, with s_tready held low.
// ----------------------------------------------------------------------------
module microcoded_stack_machine_datapath_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // load_address [15:0], load_data [51:16], zero fill [55:52]
    input  logic [msm_pkg::S_TDATA_W-1:0] s_tdata,
    // mode [1:0]
    input  logic [msm_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // next_mpc [8:0], zero_flag [9], mar_value [41:10], mdr_value [73:42],
    // pc_value [105:74], mbr_value [113:106], sp_value [145:114],
    // lv_value [177:146], cpp_value [209:178], tos_value [241:210],
    // opc_value [273:242], h_value [305:274], zero fill [311:306]
    output logic [msm_pkg::M_TDATA_W-1:0] m_tdata
);
    import msm_pkg::*;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_EXEC  = 5'b00100,
        ST_MEMW  = 5'b01000,
        ST_LOAD  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [MEM_WAW-1:0] clr_cnt_reg, clr_cnt_next;

    logic [NUM_REGS-1:0][WORD_W-1:0] regs_reg, regs_next;
    logic [BYTE_W-1:0]  mbr_reg, mbr_next;
    logic [WORD_W-1:0]  alu_out_reg, alu_out_next;
    logic               zero_reg, zero_next;
    logic [CS_AW-1:0]   mpc_reg, mpc_next;
    logic [1:0]         lane_reg, lane_next;

    logic [1:0]         pend_mode_reg;
    logic [15:0]        pend_addr_reg;
    logic [CW_W-1:0]    pend_data_reg;

    logic               out_valid_reg, out_valid_next;
    res_t               out_data_reg, out_data_next;

    logic [1:0]         in_mode;
    logic [15:0]        in_addr;
    logic [CW_W-1:0]    in_data;
    logic               out_free;
    logic               accept;
    logic               accept_exec;
    logic               push;

    cw_t                cw;
    logic [WORD_W-1:0]  c_bus;
    logic               alu_zero;
    logic [NUM_REGS-1:0][WORD_W-1:0] regs_c;
    logic [WORD_W-1:0]  fetch_word;
    logic [WORD_W-1:0]  data_word;
    logic [BYTE_W-1:0]  fetched;
    logic [BYTE_W-1:0]  mbr_step;
    logic [WORD_W-1:0]  mdr_step;
    logic [CS_AW-1:0]   mpc_step;
    logic [MEM_AW-1:0]  ld_byte_addr;
    logic               cs_wr_en;
    mem_wr_t            mem_wr;
    res_t               res;

    assign in_mode = s_tuser;
    assign in_addr = s_tdata[15:0];
    assign in_data = s_tdata[51:16];

    assign out_free    = !out_valid_reg || m_tready;
    assign s_tready    = (state_reg == ST_IDLE) || ((state_reg == ST_MEMW) && out_free);
    assign accept      = s_tvalid && s_tready;
    assign accept_exec = accept && (in_mode == MODE_EXEC);

    // Next address of the step in MEMW also addresses the control store for
    // a microstep taken in the same cycle
    msm_ctrl_store u_cs (
        .clk     (clk),
        .rd_en   (accept_exec),
        .rd_addr ((state_reg == ST_MEMW) ? mpc_step : mpc_reg),
        .rd_data (cw),
        .wr_en   (cs_wr_en),
        .wr_addr (pend_addr_reg[CS_AW-1:0]),
        .wr_data (pend_data_reg)
    );

    msm_alu u_alu (
        .cw    (cw),
        .regs  (regs_reg),
        .mbr   (mbr_reg),
        .prev  (alu_out_reg),
        .c_bus (c_bus),
        .zero  (alu_zero)
    );

    always_comb
    begin
        for (int i = 0; i < NUM_REGS; i++)
        begin
            regs_c[i] = cw.c_en[i] ? c_bus : regs_reg[i];
        end
    end

    // Memory reads see the registers after the C-bus write
    msm_main_mem u_mem (
        .clk        (clk),
        .fetch_en   ((state_reg == ST_EXEC) && cw.mem_op[MEM_FETCH_BIT]),
        .fetch_addr (regs_c[REG_PC][MEM_AW-1:2]),
        .fetch_data (fetch_word),
        .data_en    ((state_reg == ST_EXEC) && cw.mem_op[MEM_READ_BIT]),
        .data_addr  (regs_c[REG_MAR][MEM_WAW-1:0]),
        .data_data  (data_word),
        .wr         (mem_wr)
    );

    assign fetched  = fetch_word[{lane_reg, 3'b000} +: BYTE_W];
    assign mbr_step = cw.mem_op[MEM_FETCH_BIT] ? fetched : mbr_reg;
    assign mdr_step = cw.mem_op[MEM_READ_BIT] ? data_word : regs_reg[REG_MDR];
    assign mpc_step = cw.next_addr
                    | {cw.jam[JAM_Z_BIT] & zero_reg, {(CS_AW-1){1'b0}}}
                    | {cw.jam[JAM_NZ_BIT] & ~zero_reg, {(CS_AW-1){1'b0}}}
                    | (cw.jam[JAM_MPC_BIT] ? {1'b0, mbr_step} : '0);

    assign ld_byte_addr = MEM_AW'(pend_addr_reg);
    assign cs_wr_en     = (state_reg == ST_LOAD) && out_free && (pend_mode_reg == MODE_CS);

    always_comb
    begin
        mem_wr = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_wr.be   = '1;
                mem_wr.addr = clr_cnt_reg;
            end
            ST_MEMW:
            begin
                // read and write together store the word just read: skip it
                mem_wr.addr = regs_reg[REG_MAR][MEM_WAW-1:0];
                mem_wr.data = regs_reg[REG_MDR];
                if (out_free && cw.mem_op[MEM_WRITE_BIT] && !cw.mem_op[MEM_READ_BIT])
                begin
                    mem_wr.be = '1;
                end
            end
            ST_LOAD:
            begin
                mem_wr.addr = ld_byte_addr[MEM_AW-1:2];
                mem_wr.data = {LANES{pend_data_reg[BYTE_W-1:0]}};
                if (out_free && (pend_mode_reg == MODE_MEM))
                begin
                    mem_wr.be = LANES'(1) << ld_byte_addr[1:0];
                end
            end
            default:
            begin
                mem_wr = '0;
            end
        endcase
    end

    always_comb
    begin
        res          = '0;
        res.h        = regs_reg[REG_H];
        res.opc      = regs_reg[REG_OPC];
        res.tos      = regs_reg[REG_TOS];
        res.cpp      = regs_reg[REG_CPP];
        res.lv       = regs_reg[REG_LV];
        res.sp       = regs_reg[REG_SP];
        res.pc       = regs_reg[REG_PC];
        res.mar      = regs_reg[REG_MAR];
        res.zero     = zero_reg;
        if (state_reg == ST_MEMW)
        begin
            res.mbr      = mbr_step;
            res.mdr      = mdr_step;
            res.next_mpc = mpc_step;
        end
        else
        begin
            res.mbr      = mbr_reg;
            res.mdr      = regs_reg[REG_MDR];
            res.next_mpc = mpc_reg;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        regs_next    = regs_reg;
        mbr_next     = mbr_reg;
        alu_out_next = alu_out_reg;
        zero_next    = zero_reg;
        mpc_next     = mpc_reg;
        lane_next    = lane_reg;
        push         = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + MEM_WAW'(1);
                if (clr_cnt_reg == MEM_WAW'(MEM_WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = accept_exec ? ST_EXEC : ST_LOAD;
                end
            end
            ST_EXEC:
            begin
                regs_next    = regs_c;
                alu_out_next = c_bus;
                zero_next    = alu_zero;
                lane_next    = regs_c[REG_PC][1:0];
                state_next   = ST_MEMW;
            end
            ST_MEMW:
            begin
                if (out_free)
                begin
                    regs_next[REG_MDR] = mdr_step;
                    mbr_next           = mbr_step;
                    mpc_next           = mpc_step;
                    push               = 1'b1;
                    if (accept)
                    begin
                        state_next = accept_exec ? ST_EXEC : ST_LOAD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_LOAD:
            begin
                if (out_free)
                begin
                    push       = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !m_tready;
        if (push)
        begin
            out_data_next  = res;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            regs_reg      <= '0;
            mbr_reg       <= '0;
            alu_out_reg   <= '0;
            zero_reg      <= 1'b0;
            mpc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            regs_reg      <= regs_next;
            mbr_reg       <= mbr_next;
            alu_out_reg   <= alu_out_next;
            zero_reg      <= zero_next;
            mpc_reg       <= mpc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lane_reg     <= lane_next;
        out_data_reg <= out_data_next;
        if (accept)
        begin
            pend_mode_reg <= in_mode;
            pend_addr_reg <= in_addr;
            pend_data_reg <= in_data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

// ===== src/msm_ctrl_store.sv =====
// ----------------------------------------------------------------------------
// msm_ctrl_store
// Microcode store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module msm_ctrl_store (
    input  logic                       clk,
    input  logic                       rd_en,
    input  logic [msm_pkg::CS_AW-1:0]  rd_addr,
    output msm_pkg::cw_t               rd_data,
    input  logic                       wr_en,
    input  logic [msm_pkg::CS_AW-1:0]  wr_addr,
    input  logic [msm_pkg::CW_W-1:0]   wr_data
);
    import msm_pkg::*;

    logic [CW_W-1:0] store_array [CS_DEPTH];
    cw_t             rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_array[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= cw_t'(store_array[rd_addr]);
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/msm_main_mem.sv =====
// ----------------------------------------------------------------------------
// msm_main_mem
// Main memory as words of byte lanes: a fetch read port, a data read port
// and one byte-masked write port. Read data is registered.
// ----------------------------------------------------------------------------
module msm_main_mem (
    input  logic                         clk,
    input  logic                         fetch_en,
    input  logic [msm_pkg::MEM_WAW-1:0]  fetch_addr,
    output logic [msm_pkg::WORD_W-1:0]   fetch_data,
    input  logic                         data_en,
    input  logic [msm_pkg::MEM_WAW-1:0]  data_addr,
    output logic [msm_pkg::WORD_W-1:0]   data_data,
    input  msm_pkg::mem_wr_t             wr
);
    import msm_pkg::*;

    logic [WORD_W-1:0] mem_array [MEM_WORDS];
    logic [WORD_W-1:0] fetch_data_reg;
    logic [WORD_W-1:0] data_data_reg;

    always_ff @(posedge clk)
    begin
        if (fetch_en)
        begin
            fetch_data_reg <= mem_array[fetch_addr];
        end
        if (data_en)
        begin
            data_data_reg <= mem_array[data_addr];
        end
        for (int i = 0; i < LANES; i++)
        begin
            if (wr.be[i])
            begin
                mem_array[wr.addr][BYTE_W*i +: BYTE_W] <= wr.data[BYTE_W*i +: BYTE_W];
            end
        end
    end

    assign fetch_data = fetch_data_reg;
    assign data_data  = data_data_reg;

endmodule

// ===== src/msm_alu.sv =====
// ----------------------------------------------------------------------------
// msm_alu
// B bus select, ALU and shifter for one microinstruction, plus zero detect
// on the ALU result ahead of the shifter.
// ----------------------------------------------------------------------------
module msm_alu (
    input  msm_pkg::cw_t                                     cw,
    input  logic [msm_pkg::NUM_REGS-1:0][msm_pkg::WORD_W-1:0] regs,
    input  logic [msm_pkg::BYTE_W-1:0]                       mbr,
    input  logic [msm_pkg::WORD_W-1:0]                       prev,
    output logic [msm_pkg::WORD_W-1:0]                       c_bus,
    output logic                                             zero
);
    import msm_pkg::*;

    logic [WORD_W-1:0] b_bus;
    logic [WORD_W-1:0] h_bus;
    logic [WORD_W-1:0] alu_raw;

    assign h_bus = regs[REG_H];

    always_comb
    begin
        unique case (cw.b_sel)
            BSEL_MDR:  b_bus = regs[REG_MDR];
            BSEL_PC:   b_bus = regs[REG_PC];
            BSEL_MBRU: b_bus = {{(WORD_W-BYTE_W){1'b0}}, mbr};
            BSEL_MBR:  b_bus = {{(WORD_W-BYTE_W){mbr[BYTE_W-1]}}, mbr};
            BSEL_SP:   b_bus = regs[REG_SP];
            BSEL_LV:   b_bus = regs[REG_LV];
            BSEL_CPP:  b_bus = regs[REG_CPP];
            BSEL_TOS:  b_bus = regs[REG_TOS];
            BSEL_OPC:  b_bus = regs[REG_OPC];
            default:   b_bus = '1;
        endcase
    end

    always_comb
    begin
        unique case (cw.alu_op)
            ALU_AND:       alu_raw = h_bus & b_bus;
            ALU_ONE:       alu_raw = WORD_W'(1);
            ALU_MINUS_ONE: alu_raw = '1;
            ALU_PASS_B:    alu_raw = b_bus;
            ALU_PASS_H:    alu_raw = h_bus;
            ALU_NOT_H:     alu_raw = ~h_bus;
            ALU_OR:        alu_raw = h_bus | b_bus;
            ALU_NOT_B:     alu_raw = ~b_bus;
            ALU_INC_B:     alu_raw = b_bus + WORD_W'(1);
            ALU_DEC_B:     alu_raw = b_bus - WORD_W'(1);
            ALU_INC_H:     alu_raw = h_bus + WORD_W'(1);
            ALU_NEG_H:     alu_raw = WORD_W'(0) - h_bus;
            ALU_ADD:       alu_raw = h_bus + b_bus;
            ALU_ADD_INC:   alu_raw = h_bus + b_bus + WORD_W'(1);
            ALU_B_MINUS_H: alu_raw = b_bus - h_bus;
            // unknown function: hold the last C bus value
            default:       alu_raw = prev;
        endcase
    end

    assign zero = (alu_raw == '0);

    always_comb
    begin
        unique case (cw.shift)
            SH_SRL1: c_bus = {1'b0, alu_raw[WORD_W-1:1]};
            SH_SLL8: c_bus = {alu_raw[WORD_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
            default: c_bus = alu_raw;
        endcase
    end

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the microcoded stack machine datapath. A directed
// microprogram walks the datapath corner cases: B bus sources, the unknown ALU
// code, every shift, combined fetch/read/write, address wrap and all jump
// terms. Random microcode, memory loads and ignored items follow. The expected
// register file is computed for every queued item and compared against each
// output transfer. The sender runs in bursts and the receiver stalls on its
// own patterns, with one long hold-off that backs the block up.
// ----------------------------------------------------------------------------
module tb_top;
    import msm_pkg::*;

    localparam int         RANDOM_ITEMS = 400;
    localparam int         TIMEOUT_NS   = 500_000;
    localparam int         LONG_HOLD    = 300;

    localparam logic [1:0] MODE_IGNORED  = 2'd3;
    localparam logic [3:0] BSEL_ALL_ONES = 4'd15;
    localparam logic [5:0] ALU_UNDEF     = 6'd0;
    localparam logic [1:0] SH_NONE       = 2'd0;
    localparam logic [1:0] SH_NONE_ALT   = 2'd3;

    localparam logic [2:0] MEM_FETCH = 3'(1 << MEM_FETCH_BIT);
    localparam logic [2:0] MEM_READ  = 3'(1 << MEM_READ_BIT);
    localparam logic [2:0] MEM_WRITE = 3'(1 << MEM_WRITE_BIT);
    localparam logic [2:0] JAM_Z     = 3'(1 << JAM_Z_BIT);
    localparam logic [2:0] JAM_NZ    = 3'(1 << JAM_NZ_BIT);
    localparam logic [2:0] JAM_MPC   = 3'(1 << JAM_MPC_BIT);
    localparam logic [2:0] JAM_ALL   = JAM_Z | JAM_NZ | JAM_MPC;

    localparam logic [8:0] CEN_MAR = 9'(1 << REG_MAR);
    localparam logic [8:0] CEN_MDR = 9'(1 << REG_MDR);
    localparam logic [8:0] CEN_PC  = 9'(1 << REG_PC);
    localparam logic [8:0] CEN_SP  = 9'(1 << REG_SP);
    localparam logic [8:0] CEN_LV  = 9'(1 << REG_LV);
    localparam logic [8:0] CEN_CPP = 9'(1 << REG_CPP);
    localparam logic [8:0] CEN_TOS = 9'(1 << REG_TOS);
    localparam logic [8:0] CEN_OPC = 9'(1 << REG_OPC);
    localparam logic [8:0] CEN_H   = 9'(1 << REG_H);
    localparam logic [8:0] CEN_ALL = 9'h1FF;

    typedef struct packed {
        logic [1:0]      mode;
        logic [15:0]     addr;
        logic [CW_W-1:0] data;
    } step_item_t;

    logic                 clk;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    step_item_t pending_items[$];
    res_t       expected_results[$];

    // Shadow datapath state
    logic [WORD_W-1:0] dp_regs [NUM_REGS];
    logic [BYTE_W-1:0] dp_mbr;
    logic [WORD_W-1:0] dp_alu_out;
    logic              dp_zero;
    logic [CS_AW-1:0]  dp_mpc;
    logic [CW_W-1:0]   cs_image [CS_DEPTH];
    bit                cs_loaded [CS_DEPTH];
    logic [BYTE_W-1:0] mem_image [MEMORY_BYTES];

    logic [5:0] alu_codes [15] = '{ALU_AND, ALU_ONE, ALU_MINUS_ONE, ALU_PASS_B,
        ALU_PASS_H, ALU_NOT_H, ALU_OR, ALU_NOT_B, ALU_INC_B, ALU_DEC_B,
        ALU_INC_H, ALU_NEG_H, ALU_ADD, ALU_ADD_INC, ALU_B_MINUS_H};

    int unsigned mismatches   = 0;
    int unsigned results_seen = 0;
    int unsigned stim_count   = 0;

    microcoded_stack_machine_datapath_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic logic [WORD_W-1:0] b_bus(input logic [3:0] sel);
        case (sel)
            BSEL_MDR:  return dp_regs[REG_MDR];
            BSEL_PC:   return dp_regs[REG_PC];
            BSEL_MBRU: return {24'h0, dp_mbr};
            BSEL_MBR:  return {{24{dp_mbr[7]}}, dp_mbr};
            BSEL_SP:   return dp_regs[REG_SP];
            BSEL_LV:   return dp_regs[REG_LV];
            BSEL_CPP:  return dp_regs[REG_CPP];
            BSEL_TOS:  return dp_regs[REG_TOS];
            BSEL_OPC:  return dp_regs[REG_OPC];
            default:   return '1;
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] alu_result(input logic [5:0] op,
        input logic [WORD_W-1:0] h, input logic [WORD_W-1:0] b,
        input logic [WORD_W-1:0] prev);
        case (op)
            ALU_AND:       return h & b;
            ALU_ONE:       return 32'd1;
            ALU_MINUS_ONE: return '1;
            ALU_PASS_B:    return b;
            ALU_PASS_H:    return h;
            ALU_NOT_H:     return ~h;
            ALU_OR:        return h | b;
            ALU_NOT_B:     return ~b;
            ALU_INC_B:     return b + 32'd1;
            ALU_DEC_B:     return b - 32'd1;
            ALU_INC_H:     return h + 32'd1;
            ALU_NEG_H:     return 32'd0 - h;
            ALU_ADD:       return h + b;
            ALU_ADD_INC:   return h + b + 32'd1;
            ALU_B_MINUS_H: return b - h;
            default:       return prev;
        endcase
    endfunction

    // Apply one item to the shadow datapath, then queue it and its result
    task automatic queue_step(input logic [1:0] mode, input logic [15:0] addr,
        input logic [CW_W-1:0] data);
        cw_t               cw;
        logic [WORD_W-1:0] c;
        logic [WORD_W-1:0] base;
        logic [WORD_W-1:0] word;
        logic [WORD_W:0]   a;
        logic [CS_AW-1:0]  nxt;
        res_t              r;
        step_item_t        it;
        int                i;
        case (mode)
            MODE_EXEC:
            begin
                cw = cs_image[dp_mpc];
                c = alu_result(cw.alu_op, dp_regs[REG_H], b_bus(cw.b_sel), dp_alu_out);
                dp_zero = (c == '0);
                if (cw.shift == SH_SRL1)
                    c = c >> 1;
                else if (cw.shift == SH_SLL8)
                    c = c << 8;
                dp_alu_out = c;
                for (i = 0; i < NUM_REGS; i++)
                    if (cw.c_en[i])
                        dp_regs[i] = c;
                if (cw.mem_op[MEM_FETCH_BIT])
                    dp_mbr = mem_image[dp_regs[REG_PC] % MEMORY_BYTES];
                base = dp_regs[REG_MAR] << 2;
                if (cw.mem_op[MEM_READ_BIT])
                begin
                    for (i = 0; i < LANES; i++)
                    begin
                        a = {1'b0, base} + 33'(i);
                        word[8*i +: 8] = mem_image[a % MEMORY_BYTES];
                    end
                    dp_regs[REG_MDR] = word;
                end
                if (cw.mem_op[MEM_WRITE_BIT])
                begin
                    for (i = 0; i < LANES; i++)
                    begin
                        a = {1'b0, base} + 33'(i);
                        mem_image[a % MEMORY_BYTES] = dp_regs[REG_MDR][8*i +: 8];
                    end
                end
                nxt = cw.next_addr;
                if (cw.jam[JAM_Z_BIT])
                    nxt[8] = nxt[8] | dp_zero;
                if (cw.jam[JAM_NZ_BIT])
                    nxt[8] = nxt[8] | ~dp_zero;
                if (cw.jam[JAM_MPC_BIT])
                    nxt = nxt | {1'b0, dp_mbr};
                dp_mpc = nxt;
            end
            MODE_CS:
            begin
                cs_image[addr % CS_DEPTH] = data;
                cs_loaded[addr % CS_DEPTH] = 1'b1;
            end
            MODE_MEM:
                mem_image[addr % MEMORY_BYTES] = data[7:0];
            default: ;
        endcase
        if (mode != MODE_IGNORED)
            stim_count++;
        r.pad      = '0;
        r.next_mpc = dp_mpc;
        r.zero     = dp_zero;
        r.mar      = dp_regs[REG_MAR];
        r.mdr      = dp_regs[REG_MDR];
        r.pc       = dp_regs[REG_PC];
        r.mbr      = dp_mbr;
        r.sp       = dp_regs[REG_SP];
        r.lv       = dp_regs[REG_LV];
        r.cpp      = dp_regs[REG_CPP];
        r.tos      = dp_regs[REG_TOS];
        r.opc      = dp_regs[REG_OPC];
        r.h        = dp_regs[REG_H];
        expected_results.push_back(r);
        it.mode = mode;
        it.addr = addr;
        it.data = data;
        pending_items.push_back(it);
    endtask

    function automatic logic [CW_W-1:0] rand_data();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        return w[CW_W-1:0];
    endfunction

    function automatic cw_t rand_word();
        cw_t w;
        w = rand_data();
        if ($urandom_range(9, 0) != 0)
            w.alu_op = alu_codes[$urandom_range(14, 0)];
        if ($urandom_range(4, 0) != 0)
            w.b_sel = 4'($urandom_range(8, 0));
        return w;
    endfunction

    function automatic cw_t make_cw(input logic [8:0] next_addr, input logic [2:0] jam,
        input logic [1:0] shift, input logic [5:0] alu_op, input logic [8:0] c_en,
        input logic [2:0] mem_op, input logic [3:0] b_sel);
        cw_t w;
        w.next_addr = next_addr;
        w.jam       = jam;
        w.shift     = shift;
        w.alu_op    = alu_op;
        w.c_en      = c_en;
        w.mem_op    = mem_op;
        w.b_sel     = b_sel;
        return w;
    endfunction

    // Load a word at the current micro address, then execute it
    task automatic run_word(input cw_t cw);
        logic [6:0] hi;
        hi = 7'($urandom());
        queue_step(MODE_CS, {hi, dp_mpc}, cw);
        queue_step(MODE_EXEC, 16'($urandom()), rand_data());
    endtask

    // Sender: bursts of random length separated by random gaps
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    always @(posedge clk)
    begin
        if (rst_n && (!s_tvalid || s_tready))
        begin
            if (gap_left != 0 || pending_items.size() == 0)
            begin
                s_tvalid <= 1'b0;
                if (gap_left != 0)
                    gap_left <= gap_left - 1;
            end
            else
            begin
                s_tvalid <= 1'b1;
                s_tuser  <= pending_items[0].mode;
                s_tdata  <= {4'b0, pending_items[0].data, pending_items[0].addr};
                void'(pending_items.pop_front());
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(40, 1);
                    gap_left   <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
                end
                else
                    burst_left <= burst_left - 1;
            end
        end
    end

    // Receiver: stall style is redrawn at random, plus one long hold-off
    int unsigned hold_left      = 0;
    int unsigned pattern_cycle  = 0;
    int unsigned stall_style    = 0;
    bit          long_hold_done = 1'b0;

    always @(posedge clk)
    begin
        pattern_cycle <= pattern_cycle + 1;
        if (hold_left != 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (!long_hold_done && results_seen >= 120)
        begin
            long_hold_done <= 1'b1;
            hold_left      <= LONG_HOLD;
            m_tready       <= 1'b0;
        end
        else
        begin
            if (pattern_cycle % 97 == 0)
                stall_style <= $urandom_range(3, 0);
            case (stall_style)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(1, 0) == 1);
                2:       m_tready <= ($urandom_range(3, 0) == 0);
                default: m_tready <= (pattern_cycle % 8 != 5);
            endcase
        end
    end

    task automatic check_field(input string name, input logic [WORD_W-1:0] want,
        input logic [WORD_W-1:0] seen);
        if (seen !== want)
        begin
            $error("%s: expected %0h, actual %0h", name, want, seen);
            mismatches++;
        end
    endtask

    res_t got_res;
    res_t want_res;

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_res = m_tdata;
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0)
            begin
                $error("result transfer with nothing expected, next_mpc %0h",
                    got_res.next_mpc);
                mismatches++;
            end
            else
            begin
                want_res = expected_results.pop_front();
                check_field("next_mpc", WORD_W'(want_res.next_mpc), WORD_W'(got_res.next_mpc));
                check_field("zero_flag", WORD_W'(want_res.zero), WORD_W'(got_res.zero));
                check_field("mar_value", want_res.mar, got_res.mar);
                check_field("mdr_value", want_res.mdr, got_res.mdr);
                check_field("pc_value", want_res.pc, got_res.pc);
                check_field("mbr_value", WORD_W'(want_res.mbr), WORD_W'(got_res.mbr));
                check_field("sp_value", want_res.sp, got_res.sp);
                check_field("lv_value", want_res.lv, got_res.lv);
                check_field("cpp_value", want_res.cpp, got_res.cpp);
                check_field("tos_value", want_res.tos, got_res.tos);
                check_field("opc_value", want_res.opc, got_res.opc);
                check_field("h_value", want_res.h, got_res.h);
            end
        end
    end

    initial
    begin
        int         i;
        int         pick;
        logic [6:0] hi;
        logic [31:0] a;

        for (i = 0; i < NUM_REGS; i++)
            dp_regs[i] = '0;
        dp_mbr     = '0;
        dp_alu_out = '0;
        dp_zero    = 1'b0;
        dp_mpc     = '0;
        for (i = 0; i < CS_DEPTH; i++)
            cs_loaded[i] = 1'b0;
        for (i = 0; i < MEMORY_BYTES; i++)
            mem_image[i] = '0;

        // Directed microprogram
        queue_step(MODE_MEM, 16'h0000, {28'hFFFFFFF, 8'h80});
        queue_step(MODE_MEM, 16'hFFFF, 36'h0_0000_005A);
        run_word(make_cw(9'h010, 3'b0, SH_NONE, ALU_ONE, 9'h0, MEM_FETCH, BSEL_MDR));
        // sign-extended byte into every register
        run_word(make_cw(9'h011, 3'b0, SH_NONE, ALU_PASS_B, CEN_ALL, 3'b0, BSEL_MBR));
        run_word(make_cw(9'h012, 3'b0, SH_SRL1, ALU_PASS_B, CEN_H, 3'b0, BSEL_ALL_ONES));
        // unknown code reuses the previous result, then shifts it again
        run_word(make_cw(9'h013, JAM_Z, SH_SLL8, ALU_UNDEF, CEN_TOS, 3'b0, BSEL_MDR));
        run_word(make_cw(9'h014, 3'b0, SH_NONE_ALT, ALU_MINUS_ONE, CEN_PC | CEN_H, 3'b0,
            BSEL_MDR));
        // zero result, fetch at the top byte, read then write back at MAR 0
        run_word(make_cw(9'h0AA, JAM_ALL, SH_NONE, ALU_INC_H, CEN_MAR,
            MEM_FETCH | MEM_READ | MEM_WRITE, BSEL_MBRU));
        run_word(make_cw(9'h020, JAM_NZ, SH_NONE, ALU_PASS_H, CEN_MDR, MEM_WRITE, BSEL_MDR));
        run_word(make_cw(9'h021, JAM_MPC, SH_NONE, ALU_ADD,
            CEN_SP | CEN_LV | CEN_CPP | CEN_OPC, MEM_READ, BSEL_MDR));
        queue_step(MODE_IGNORED, 16'hFFFF, '1);
        queue_step(MODE_CS, 16'hFFFF, '1);
        queue_step(MODE_MEM, 16'h8000, 36'hF_FFFF_FF00);

        // Random microcode, memory loads and noise
        while (stim_count < 21 + RANDOM_ITEMS)
        begin
            pick = $urandom_range(99, 0);
            if (pick < 65)
            begin
                if (!cs_loaded[dp_mpc] || $urandom_range(9, 0) < 3)
                begin
                    hi = 7'($urandom());
                    queue_step(MODE_CS, {hi, dp_mpc}, rand_word());
                end
                queue_step(MODE_EXEC, 16'($urandom()), rand_data());
            end
            else if (pick < 75)
                queue_step(MODE_CS, 16'($urandom()), rand_word());
            else if (pick < 95)
            begin
                case ($urandom_range(3, 0))
                    0:       a = $urandom_range(1023, 0);
                    1:       a = $urandom();
                    2:       a = dp_regs[REG_PC];
                    default: a = (dp_regs[REG_MAR] << 2) + $urandom_range(3, 0);
                endcase
                queue_step(MODE_MEM, a[15:0], rand_data());
            end
            else
                queue_step(MODE_IGNORED, 16'($urandom()), rand_data());
        end

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_items.size() == 0 && !s_tvalid);
        wait (expected_results.size() == 0);
        repeat (20) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("tb_top: FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
src/msm_pkg.sv
src/msm_ctrl_store.sv
src/msm_main_mem.sv
src/msm_alu.sv
src/microcoded_stack_machine_datapath_unit.sv
tb/sv/tb_top.sv
